// ===== hw/rtl/lep_pkg.sv =====
// Shared types and constants for the longest expressible prefix block.
package lep_pkg;

    // Fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 8;
    localparam int LEN_W      = 4;
    localparam int LETTERS_W  = 50;
    localparam int LETTER_W   = 5;
    localparam int BEST_W     = 20;

    // Sliding window of recent letters and prefix flags
    localparam int WINDOW     = 12;
    localparam int AVAIL_W    = 4;

    // Defaults for top-level parameters
    localparam int DEF_DICT_DEPTH   = 256;
    localparam int DEF_MAX_PRIM_LEN = 10;
    localparam int DEF_COUNT_BITS   = 20;

    // Input tdata layout, lowest bit first
    localparam int IN_INDEX_LSB   = 0;
    localparam int IN_LEN_LSB     = IN_INDEX_LSB + INDEX_W;
    localparam int IN_LETTERS_LSB = IN_LEN_LSB + LEN_W;
    localparam int IN_LETTER_LSB  = IN_LETTERS_LSB + LETTERS_W;
    localparam int IN_USED_W      = IN_LETTER_LSB + LETTER_W;
    localparam int IN_DATA_W      = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_BEST_LSB    = 0;
    localparam int OUT_MATCHED_BIT = OUT_BEST_LSB + BEST_W;
    localparam int OUT_STOPPED_BIT = OUT_MATCHED_BIT + 1;
    localparam int OUT_USED_W      = OUT_STOPPED_BIT + 1;
    localparam int OUT_DATA_W      = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_WRITE   = 2'd1,
        OP_LETTER  = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SCAN,
        ST_POST
    } state_t;

    typedef logic [WINDOW-1:0][LETTER_W-1:0] window_letters_t;

    // Run context the matcher compares each dictionary entry against
    typedef struct packed {
        window_letters_t        letters;   // index 0 is the newest letter
        logic [WINDOW-1:0]      flags;     // bit k: prefix of length count-k
        logic [AVAIL_W-1:0]     avail;     // letters in window, capped at WINDOW
    } window_t;

    // Tag that travels with a RAM read
    typedef struct packed {
        logic valid;
        logic last;
    } rd_tag_t;

    // Per-entry match verdict
    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } match_t;

endpackage

// ===== hw/rtl/longest_expressible_prefix.sv =====
// Top level: longest expressible prefix over a letter stream, word-break style.
//
// Input channel s_axis carries one item per handshake: tuser holds the opcode
// (clear, write primitive, sequence letter, restart) and tdata the payload.
// Output channel m_axis returns exactly one result item per input item, in
// order: best prefix length so far, whether the prefix ending at this letter
// is expressible, and whether the run has stopped.
//
// The dictionary sits in one RAM word per slot ({valid, length, letters}).
// A letter scans the RAM one entry per cycle through a matcher stage and ends
// early on the first hit. Writes, restarts and letters ignored after a stop
// are answered without a scan. A clear sweeps the RAM to invalid before its
// result is posted.
//
// After reset the same sweep runs with s_axis_tready low. One item is worked
// on at a time; a finished result waits in the output register, so a stalled
// receiver does not stop the next item from being accepted, only its result
// from being posted.
module longest_expressible_prefix #(
    parameter int DICT_DEPTH   = lep_pkg::DEF_DICT_DEPTH,
    parameter int MAX_PRIM_LEN = lep_pkg::DEF_MAX_PRIM_LEN,
    parameter int COUNT_BITS   = lep_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] entry_index, [11:8] entry_length, [61:12] entry_letters,
    // [66:62] letter, rest zero
    input  logic [lep_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [lep_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [19:0] best_length, [20] matched_now, [21] stopped, rest zero
    output logic [lep_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW     = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int LW     = lep_pkg::LETTER_W * MAX_PRIM_LEN;
    localparam int WORD_W = LW + lep_pkg::LEN_W + 1;
    localparam int WIN    = lep_pkg::WINDOW;

    // ---------------- input field decode ----------------
    lep_pkg::opcode_t                in_op;
    logic [lep_pkg::INDEX_W-1:0]     in_index;
    logic [lep_pkg::LEN_W-1:0]       in_len;
    logic [lep_pkg::LETTERS_W-1:0]   in_letters;
    logic [lep_pkg::LETTER_W-1:0]    in_letter;
    logic                            wr_ok;

    assign in_op      = lep_pkg::opcode_t'(s_axis_tuser);
    assign in_index   = s_axis_tdata[lep_pkg::IN_INDEX_LSB +: lep_pkg::INDEX_W];
    assign in_len     = s_axis_tdata[lep_pkg::IN_LEN_LSB +: lep_pkg::LEN_W];
    assign in_letters = s_axis_tdata[lep_pkg::IN_LETTERS_LSB +: lep_pkg::LETTERS_W];
    assign in_letter  = s_axis_tdata[lep_pkg::IN_LETTER_LSB +: lep_pkg::LETTER_W];

    // out-of-range slot or length: write dropped
    assign wr_ok = (32'(in_index) < 32'(DICT_DEPTH)) && (in_len != '0)
                   && (32'(in_len) <= 32'(MAX_PRIM_LEN));

    // ---------------- state ----------------
    lep_pkg::state_t                 state_reg, state_next;
    logic [AW-1:0]                   sweep_addr_reg, sweep_addr_next;
    logic                            owe_reg, owe_next;        // clear result pending
    logic [AW-1:0]                   iss_addr_reg, iss_addr_next;
    logic                            iss_done_reg, iss_done_next;
    lep_pkg::rd_tag_t                tag_reg, tag_next;

    lep_pkg::window_letters_t        letters_reg, letters_next;
    logic [WIN-1:0]                  flags_reg, flags_next;
    logic [COUNT_BITS-1:0]           seen_reg, seen_next;
    logic [COUNT_BITS-1:0]           trail_reg, trail_next;
    logic [lep_pkg::LEN_W-1:0]       longest_reg, longest_next;
    logic                            halted_reg, halted_next;
    logic                            matched_reg, matched_next;

    logic                            out_valid_reg, out_valid_next;
    logic [lep_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    // RAM ports
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [WORD_W-1:0]               wr_data;
    logic                            rd_en;
    logic [WORD_W-1:0]               rd_data;
    logic                            iss_last;

    lep_pkg::window_t                win;
    lep_pkg::match_t                 match;
    logic                            stop_cond;
    logic                            load_out;
    logic [COUNT_BITS-1:0]           best_full;

    assign iss_last  = (iss_addr_reg == AW'(DICT_DEPTH - 1));
    assign stop_cond = (trail_reg >= COUNT_BITS'(longest_reg)) || (seen_reg == '1);
    assign best_full = seen_reg - trail_reg;

    // window context: letters available counts the incoming letter
    always_comb
    begin
        win.letters = letters_reg;
        win.flags   = flags_reg;
        if (seen_reg >= COUNT_BITS'(WIN - 1))
        begin
            win.avail = lep_pkg::AVAIL_W'(WIN);
        end
        else
        begin
            win.avail = lep_pkg::AVAIL_W'(seen_reg) + lep_pkg::AVAIL_W'(1);
        end
    end

    // ---------------- dictionary RAM and matcher ----------------
    lep_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (iss_addr_reg),
        .rd_data (rd_data)
    );

    lep_match #(
        .MAX_PRIM_LEN (MAX_PRIM_LEN)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_tag  (tag_reg),
        .rd_data (rd_data),
        .win     (win),
        .match   (match)
    );

    // ---------------- control and datapath ----------------
    // Writes happen only at accept or during the sweep, reads only in SCAN,
    // and a new scan is reached only by way of POST and IDLE after the last read
    // issue, so no read ever overlaps a write to the same slot or a stale verdict.
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        owe_next        = owe_reg;
        iss_addr_next   = iss_addr_reg;
        iss_done_next   = iss_done_reg;
        letters_next    = letters_reg;
        flags_next      = flags_reg;
        seen_next       = seen_reg;
        trail_next      = trail_reg;
        longest_next    = longest_reg;
        halted_next     = halted_reg;
        matched_next    = matched_reg;

        wr_en         = 1'b0;
        wr_addr       = sweep_addr_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;

        unique case (state_reg)
            lep_pkg::ST_SWEEP:
            begin
                wr_en = 1'b1;   // invalid word
                if (sweep_addr_reg == AW'(DICT_DEPTH - 1))
                begin
                    state_next = owe_reg ? lep_pkg::ST_POST : lep_pkg::ST_IDLE;
                    owe_next   = 1'b0;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end

            lep_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    matched_next = 1'b0;
                    state_next   = lep_pkg::ST_POST;
                    unique case (in_op)
                        lep_pkg::OP_CLEAR:
                        begin
                            letters_next    = '0;
                            flags_next      = WIN'(1);
                            seen_next       = '0;
                            trail_next      = '0;
                            halted_next     = 1'b0;
                            longest_next    = '0;
                            sweep_addr_next = '0;
                            owe_next        = 1'b1;
                            state_next      = lep_pkg::ST_SWEEP;
                        end
                        lep_pkg::OP_WRITE:
                        begin
                            if (wr_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(in_index);
                                wr_data = {1'b1, in_len, LW'(in_letters)};
                                if (in_len > longest_reg)
                                begin
                                    longest_next = in_len;
                                end
                            end
                        end
                        lep_pkg::OP_RESTART:
                        begin
                            letters_next = '0;
                            flags_next   = WIN'(1);
                            seen_next    = '0;
                            trail_next   = '0;
                            halted_next  = 1'b0;
                        end
                        lep_pkg::OP_LETTER:
                        begin
                            if (!halted_reg)
                            begin
                                if (stop_cond)
                                begin
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    letters_next  = lep_pkg::window_letters_t'(
                                                        {letters_reg[WIN-2:0], in_letter});
                                    iss_addr_next = '0;
                                    iss_done_next = 1'b0;
                                    state_next    = lep_pkg::ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = lep_pkg::ST_POST;
                        end
                    endcase
                end
            end

            lep_pkg::ST_SCAN:
            begin
                if (!iss_done_reg)
                begin
                    rd_en = 1'b1;
                    if (iss_last)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_addr_next = iss_addr_reg + AW'(1);
                    end
                end
                if (match.valid && (match.hit || match.last))
                begin
                    matched_next = match.hit;
                    flags_next   = {flags_reg[WIN-2:0], match.hit};
                    seen_next    = seen_reg + COUNT_BITS'(1);
                    if (match.hit)
                    begin
                        trail_next = '0;
                    end
                    else if (trail_reg != '1)
                    begin
                        trail_next = trail_reg + COUNT_BITS'(1);
                    end
                    iss_done_next = 1'b1;
                    state_next    = lep_pkg::ST_POST;
                end
            end

            lep_pkg::ST_POST:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = lep_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lep_pkg::ST_IDLE;
            end
        endcase

        // read tag follows the RAM latency
        tag_next.valid = rd_en;
        tag_next.last  = iss_last;

        // output register
        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next = '0;
            out_data_next[lep_pkg::OUT_BEST_LSB +: lep_pkg::BEST_W] =
                lep_pkg::BEST_W'(best_full);
            out_data_next[lep_pkg::OUT_MATCHED_BIT] = matched_reg;
            out_data_next[lep_pkg::OUT_STOPPED_BIT] = halted_reg;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lep_pkg::ST_SWEEP;
            sweep_addr_reg <= '0;
            owe_reg        <= 1'b0;
            iss_addr_reg   <= '0;
            iss_done_reg   <= 1'b1;
            tag_reg        <= '0;
            letters_reg    <= '0;
            flags_reg      <= WIN'(1);
            seen_reg       <= '0;
            trail_reg      <= '0;
            longest_reg    <= '0;
            halted_reg     <= 1'b0;
            matched_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            owe_reg        <= owe_next;
            iss_addr_reg   <= iss_addr_next;
            iss_done_reg   <= iss_done_next;
            tag_reg        <= tag_next;
            letters_reg    <= letters_next;
            flags_reg      <= flags_next;
            seen_reg       <= seen_next;
            trail_reg      <= trail_next;
            longest_reg    <= longest_next;
            halted_reg     <= halted_next;
            matched_reg    <= matched_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // dictionary is never written while a scan reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != lep_pkg::ST_SCAN))
        else $error("dictionary write during scan");

    // trailing misses never exceed letters taken
    a_trail_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        trail_reg <= seen_reg)
        else $error("trailing misses exceed seen count");

    // newest prefix flag agrees with the miss run
    a_flag_vs_trail: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[0] == (trail_reg == '0))
        else $error("newest prefix flag disagrees with trailing misses");

endmodule

// ===== hw/rtl/lep_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module lep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lep_match.sv =====
// Compares one dictionary entry per cycle against the letter window.
module lep_match #(
    parameter int MAX_PRIM_LEN = lep_pkg::DEF_MAX_PRIM_LEN,
    localparam int LW     = lep_pkg::LETTER_W * MAX_PRIM_LEN,
    localparam int WORD_W = LW + lep_pkg::LEN_W + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lep_pkg::rd_tag_t  rd_tag,
    input  logic [WORD_W-1:0] rd_data,
    input  lep_pkg::window_t  win,
    output lep_pkg::match_t   match
);

    logic [LW-1:0]                   ent_letters;
    logic [lep_pkg::LEN_W-1:0]       ent_len;
    logic                            ent_valid;
    logic                            len_ok;
    logic                            flag_ok;
    logic                            letters_ok;
    logic [lep_pkg::AVAIL_W-1:0]     pos;
    lep_pkg::match_t                 match_reg;
    lep_pkg::match_t                 match_next;

    // entry word: {valid, length, letters}
    assign ent_letters = rd_data[LW-1:0];
    assign ent_len     = rd_data[LW +: lep_pkg::LEN_W];
    assign ent_valid   = rd_data[WORD_W-1];

    always_comb
    begin
        len_ok = ent_valid && (ent_len != '0)
                 && (32'(ent_len) <= 32'(MAX_PRIM_LEN))
                 && (32'(ent_len) <= 32'(win.avail));

        // flag of the prefix just before the primitive
        flag_ok = 1'b0;
        for (int k = 0; k < lep_pkg::WINDOW; k++)
        begin
            if (ent_len == lep_pkg::LEN_W'(k + 1))
            begin
                flag_ok = win.flags[k];
            end
        end

        // first primitive letter lines up with window slot len-1
        letters_ok = 1'b1;
        pos        = '0;
        for (int i = 0; i < MAX_PRIM_LEN; i++)
        begin
            if (lep_pkg::LEN_W'(i) < ent_len)
            begin
                pos = lep_pkg::AVAIL_W'(ent_len - lep_pkg::LEN_W'(i + 1));
                if (ent_letters[lep_pkg::LETTER_W*i +: lep_pkg::LETTER_W] != win.letters[pos])
                begin
                    letters_ok = 1'b0;
                end
            end
        end

        match_next.valid = rd_tag.valid;
        match_next.last  = rd_tag.last;
        match_next.hit   = rd_tag.valid && len_ok && flag_ok && letters_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

// ===== sim/lep_checker.sv =====
`timescale 1ns / 1ps
// Checker for the longest expressible prefix block: tracks word-break state and compares results.
module lep_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lep_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [lep_pkg::OPCODE_W-1:0]   s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lep_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             mismatches,
    output int                             outstanding
);

    localparam int DEPTH  = lep_pkg::DEF_DICT_DEPTH;
    localparam int MAXLEN = lep_pkg::DEF_MAX_PRIM_LEN;
    localparam int CB     = lep_pkg::DEF_COUNT_BITS;
    localparam int WIN    = lep_pkg::WINDOW;
    localparam int LTR_W  = lep_pkg::LETTER_W;
    localparam int BEST_W = lep_pkg::BEST_W;

    typedef struct packed {
        logic [BEST_W-1:0] best;
        logic              matched;
        logic              stopped;
    } prefix_report_t;

    // Dictionary and run state
    bit [lep_pkg::LETTERS_W-1:0] prim_word [DEPTH];
    bit [lep_pkg::LEN_W-1:0]     prim_len  [DEPTH];
    bit                          prim_live [DEPTH];
    bit [LTR_W-1:0]              tail_letters [WIN];   // index 0 newest
    bit [WIN-1:0]                tail_flags;           // bit k: prefix of length letters_seen-k
    bit [CB-1:0]                 letters_seen;
    bit [CB-1:0]                 miss_run;
    bit [lep_pkg::LEN_W-1:0]     longest_len;
    bit                          halted;

    prefix_report_t reports_q [$];

    function automatic void reset_run_state();
        for (int k = 0; k < WIN; k++)
            tail_letters[k] = '0;
        tail_flags   = WIN'(1);
        letters_seen = '0;
        miss_run     = '0;
        halted       = 1'b0;
    endfunction

    function automatic void clear_all();
        for (int e = 0; e < DEPTH; e++)
        begin
            prim_live[e] = 1'b0;
            prim_len[e]  = '0;
            prim_word[e] = '0;
        end
        longest_len = '0;
        reset_run_state();
    endfunction

    // Does entry e end exactly at the newest letter, given cnt letters in the run
    function automatic bit ends_here(int e, longint unsigned cnt);
        int n;
        n = int'(prim_len[e]);
        if (!prim_live[e] || n == 0 || n > MAXLEN || n > cnt)
            return 1'b0;
        if (!tail_flags[n-1])
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (prim_word[e][LTR_W*i +: LTR_W] != tail_letters[n-1-i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic prefix_report_t step_prefix(lep_pkg::opcode_t op,
                                                   logic [lep_pkg::IN_DATA_W-1:0] d);
        prefix_report_t          r;
        bit                      hit;
        bit [lep_pkg::LEN_W-1:0] len;
        bit [lep_pkg::INDEX_W-1:0] idx;
        longint unsigned         cnt;
        hit = 1'b0;
        case (op)
            lep_pkg::OP_CLEAR:
                clear_all();
            lep_pkg::OP_WRITE:
            begin
                len = d[lep_pkg::IN_LEN_LSB +: lep_pkg::LEN_W];
                idx = d[lep_pkg::IN_INDEX_LSB +: lep_pkg::INDEX_W];
                if (int'(idx) < DEPTH && len >= 1 && len <= MAXLEN)
                begin
                    prim_word[idx] = d[lep_pkg::IN_LETTERS_LSB +: lep_pkg::LETTERS_W];
                    prim_len[idx]  = len;
                    prim_live[idx] = 1'b1;
                    if (len > longest_len)
                        longest_len = len;
                end
            end
            lep_pkg::OP_LETTER:
            begin
                if (!halted)
                begin
                    if (miss_run >= CB'(longest_len) || letters_seen == '1)
                        halted = 1'b1;
                    else
                    begin
                        cnt = 64'(letters_seen) + 64'd1;
                        for (int k = WIN - 1; k > 0; k--)
                            tail_letters[k] = tail_letters[k-1];
                        tail_letters[0] = d[lep_pkg::IN_LETTER_LSB +: LTR_W];
                        for (int e = 0; e < DEPTH && !hit; e++)
                            hit = ends_here(e, cnt);
                        tail_flags   = {tail_flags[WIN-2:0], hit};
                        letters_seen = cnt[CB-1:0];
                        if (hit)
                            miss_run = '0;
                        else if (miss_run != '1)
                            miss_run = miss_run + CB'(1);
                    end
                end
            end
            default:
                reset_run_state();
        endcase
        r.best    = BEST_W'(letters_seen - miss_run);
        r.matched = hit;
        r.stopped = halted;
        return r;
    endfunction

    always @(posedge clk)
    begin
        prefix_report_t exp_r;
        int             errs;
        errs = 0;
        if (!rst_n)
            clear_all();
        else
        begin
            if (s_tvalid && s_tready)
                reports_q.push_back(step_prefix(lep_pkg::opcode_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (reports_q.size() == 0)
                begin
                    $error("result item with nothing outstanding: best_length %0d",
                           m_tdata[lep_pkg::OUT_BEST_LSB +: BEST_W]);
                    errs++;
                end
                else
                begin
                    exp_r = reports_q.pop_front();
                    if (m_tdata[lep_pkg::OUT_BEST_LSB +: BEST_W] !== exp_r.best)
                    begin
                        $error("best_length: expected %0d, got %0d",
                               exp_r.best, m_tdata[lep_pkg::OUT_BEST_LSB +: BEST_W]);
                        errs++;
                    end
                    if (m_tdata[lep_pkg::OUT_MATCHED_BIT] !== exp_r.matched)
                    begin
                        $error("matched_now: expected %0d, got %0d",
                               exp_r.matched, m_tdata[lep_pkg::OUT_MATCHED_BIT]);
                        errs++;
                    end
                    if (m_tdata[lep_pkg::OUT_STOPPED_BIT] !== exp_r.stopped)
                    begin
                        $error("stopped: expected %0d, got %0d",
                               exp_r.stopped, m_tdata[lep_pkg::OUT_STOPPED_BIT]);
                        errs++;
                    end
                    if (m_tdata[lep_pkg::OUT_DATA_W-1:lep_pkg::OUT_USED_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_tdata[lep_pkg::OUT_DATA_W-1:lep_pkg::OUT_USED_W]);
                        errs++;
                    end
                end
            end
            mismatches  <= mismatches + errs;
            outstanding <= reports_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the longest expressible prefix block: stimulus, idling and verdict.
module tb;

    localparam int ITEM_TARGET  = 1800;
    localparam int IDLE_LIMIT   = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 300;    // longer than a full dictionary scan
    localparam int IDX_W        = lep_pkg::INDEX_W;
    localparam int LEN_W        = lep_pkg::LEN_W;
    localparam int WORD_W       = lep_pkg::LETTERS_W;
    localparam int LTR_W        = lep_pkg::LETTER_W;

    typedef enum int {
        RX_OPEN,     // always ready
        RX_RANDOM,   // ready at random, about two times in three
        RX_BURSTY,   // ready, with occasional long stalls
        RX_TOGGLE    // ready every other cycle
    } rx_mode_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [lep_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [lep_pkg::OPCODE_W-1:0]   s_axis_tuser = lep_pkg::OP_CLEAR;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lep_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;

    longest_expressible_prefix u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lep_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver side: the stall pattern switches mode at random intervals,
    // so stalls land on writes, scans and ignored letters alike,
    // with open stretches in between.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_phase_left = 0;
    int       rx_hold = 0;

    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       <= rx_mode_t'($urandom_range(0, 3));
            rx_phase_left <= int'($urandom_range(50, 600));
        end
        else
            rx_phase_left <= rx_phase_left - 1;

        if (rx_hold != 0)
        begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:
                    m_axis_tready <= 1'b1;
                RX_RANDOM:
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                RX_BURSTY:
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        rx_hold <= int'($urandom_range(5, 60));
                end
                default:
                    m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a hang shows up as a long stretch with no item moving.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side and a shadow of the dictionary, used only to build
    // letter streams that are concatenations of stored primitives.
    // ------------------------------------------------------------------
    int              items_sent = 0;
    int              burst_left = 0;
    int              live_slots [$];
    bit              slot_used [256];
    bit [LEN_W-1:0]  slot_len  [256];
    bit [WORD_W-1:0] slot_word [256];

    function automatic bit [WORD_W-1:0] rand_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    // Small alphabet most of the time so primitives overlap and collide
    function automatic bit [LTR_W-1:0] pick_letter();
        return LTR_W'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 31));
    endfunction

    // One item through the handshake; bursts of random length, random gaps
    task automatic send_item(lep_pkg::opcode_t op, bit [IDX_W-1:0] idx,
                             bit [LEN_W-1:0] len, bit [WORD_W-1:0] word,
                             bit [LTR_W-1:0] ltr);
        logic [lep_pkg::IN_DATA_W-1:0] d;
        int                            gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(40, 120))
                                                      : int'($urandom_range(1, 12));
        end
        d = '0;
        d[lep_pkg::IN_INDEX_LSB +: IDX_W]    = idx;
        d[lep_pkg::IN_LEN_LSB +: LEN_W]      = len;
        d[lep_pkg::IN_LETTERS_LSB +: WORD_W] = word;
        d[lep_pkg::IN_LETTER_LSB +: LTR_W]   = ltr;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Clear or restart; the payload is junk the block must ignore
    task automatic send_control(lep_pkg::opcode_t op);
        send_item(op, IDX_W'($urandom), LEN_W'($urandom), rand_word(), LTR_W'($urandom));
        if (op == lep_pkg::OP_CLEAR)
        begin
            live_slots.delete();
            for (int e = 0; e < 256; e++)
                slot_used[e] = 1'b0;
        end
    endtask

    task automatic write_prim(bit [IDX_W-1:0] idx, bit [LEN_W-1:0] len,
                              bit [WORD_W-1:0] word);
        send_item(lep_pkg::OP_WRITE, idx, len, word, LTR_W'($urandom));
        if (len >= 1 && len <= lep_pkg::DEF_MAX_PRIM_LEN)
        begin
            if (!slot_used[idx])
                live_slots.push_back(int'(idx));
            slot_used[idx] = 1'b1;
            slot_len[idx]  = len;
            slot_word[idx] = word;
        end
    endtask

    task automatic send_letter(bit [LTR_W-1:0] ltr);
        send_item(lep_pkg::OP_LETTER, IDX_W'($urandom), LEN_W'($urandom), rand_word(), ltr);
    endtask

    // Mostly short primitives, some long ones, and the odd malformed write
    task automatic build_dictionary(int count);
        bit [LEN_W-1:0]  len;
        bit [WORD_W-1:0] word;
        repeat (count)
        begin
            word = rand_word();
            if ($urandom_range(0, 11) == 0)
                len = ($urandom_range(0, 1) != 0) ? '0 : LEN_W'($urandom_range(11, 15));
            else
            begin
                len = LEN_W'(($urandom_range(0, 3) == 0)
                             ? $urandom_range(1, lep_pkg::DEF_MAX_PRIM_LEN)
                             : $urandom_range(1, 3));
                for (int i = 0; i < int'(len); i++)
                    word[LTR_W*i +: LTR_W] = pick_letter();
            end
            write_prim(IDX_W'($urandom), len, word);
        end
    endtask

    task automatic emit_primitive(int slot);
        for (int i = 0; i < int'(slot_len[slot]); i++)
            send_letter(slot_word[slot][LTR_W*i +: LTR_W]);
    endtask

    initial
    begin
        int choice;
        int nprims;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed items ---
        send_control(lep_pkg::OP_CLEAR);
        send_letter(5'd31);                 // empty dictionary: stops at once
        send_letter(5'd5);                  // ignored while stopped
        write_prim(8'd5, 4'd0, '1);         // malformed writes, all dropped
        write_prim(8'd6, 4'd11, '1);
        write_prim(8'd255, 4'd15, '1);
        send_control(lep_pkg::OP_RESTART);
        // slot 255: ten letters of code 31; slot 0: 'A' with junk above it
        write_prim(8'd255, 4'd10, '1);
        write_prim(8'd0, 4'd1, {{(WORD_W-5){1'b1}}, 5'd0});
        // nine misses (short history), then the long primitive closes
        repeat (10) send_letter(5'd31);
        send_letter(5'd0);
        write_prim(8'd128, 4'd3, {35'h0, 5'd3, 5'd2, 5'd1});
        send_letter(5'd1);
        send_letter(5'd2);
        send_letter(5'd3);
        send_letter(5'd26);
        send_control(lep_pkg::OP_RESTART);
        // overwrite with a shorter primitive: longest length is kept
        write_prim(8'd255, 4'd2, {40'h0, 5'd1, 5'd0});

        // --- random phases: dictionaries, then mostly well-formed streams ---
        while (items_sent < ITEM_TARGET)
        begin
            choice = int'($urandom_range(0, 9));
            if (live_slots.size() == 0 || choice == 0)
            begin
                send_control(lep_pkg::OP_CLEAR);
                build_dictionary(($urandom_range(0, 4) == 0) ? int'($urandom_range(12, 40))
                                                             : int'($urandom_range(1, 8)));
            end
            else if (choice == 1)
                build_dictionary(int'($urandom_range(1, 3)));   // grows without a clear, before a restart
            if (choice < 8)
                send_control(lep_pkg::OP_RESTART);
            nprims = int'($urandom_range(2, 25));
            repeat (nprims)
            begin
                if ($urandom_range(0, 14) == 0)
                    send_letter(pick_letter());           // noise breaks alignment
                if (live_slots.size() != 0)
                    emit_primitive(live_slots[$urandom_range(0, live_slots.size() - 1)]);
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the checker's count catch up, drain, then a quiet tail
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
